FILE: hdl/pdpp_pkg.sv
// ----------------------------------------------------------------------------
// pdpp_pkg
// Shared types, constants and the arctangent table of the photon packer.
// ----------------------------------------------------------------------------
package pdpp_pkg;

   localparam int DIR_W    = 16;
   localparam int POW_W    = 31;
   localparam int CODE_W   = 8;
   localparam int STEPS    = 24;
   localparam int ROOT_W   = 16;
   localparam int RAD_W    = 32;
   localparam int VEC_W    = 36;
   localparam int ACC_W    = 34;
   localparam logic [POW_W-1:0] BLACK_LIMIT = 31'h0A4FB11F;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic [CODE_W-1:0] red;
      logic [CODE_W-1:0] green;
      logic [CODE_W-1:0] blue;
      logic [CODE_W-1:0] expo;
   } rgbe_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      acc_type acc;
   } rot_type;

   function automatic acc_type atan_unit(input int i);
      logic [31:0] t;
      case (i)
         0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
         3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
         9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
         12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2F9;
         15: t = 32'h0000517C;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
         18: t = 32'h00000A2F;  19: t = 32'h00000517;  20: t = 32'h0000028B;
         21: t = 32'h00000145;  22: t = 32'h000000A2;  23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return acc_type'({2'b00, t});
   endfunction

   function automatic logic [CODE_W-1:0] mant_byte(input logic [POW_W-1:0] bits,
                                                   input logic [7:0] top_exp);
      logic [7:0]  e;
      logic [23:0] m;
      logic [8:0]  sh;
      e = bits[30:23];
      m = {(e != 8'd0), bits[22:0]};
      if (e == 8'd0) e = 8'd1;
      sh = {1'b0, top_exp} - {1'b0, e} + 9'd16;
      if (e > top_exp || sh >= 9'd24) return '0;
      return CODE_W'(m >> sh[4:0]);
   endfunction

endpackage

FILE: hdl/pdpp_stream_if.sv
// ----------------------------------------------------------------------------
// pdpp_stream_if
// Valid/ready channel carrying a payload of parameter type.
// ----------------------------------------------------------------------------
interface pdpp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/photon_direction_power_packer_top.sv
// ----------------------------------------------------------------------------
// photon_direction_power_packer_top
// Packs a photon's unit direction into polar/azimuth bytes and its power
// into shared-exponent RGBE bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries direction_x/y/z (Q1.15) and power_red/green/blue (float bits).
//   rsp carries polar_code, azimuth_code, the three mantissas and
//   shared_exponent, one result per request transfer.
//   Throughput: one transfer per cycle while the output is not stalled. The
//   path is the 16-cell square root chain followed by the 24-cell CORDIC
//   chain; the azimuth and RGBE data ride in delay registers alongside.
//   The whole chain advances only when the output register is free or being
//   taken, so a stalled receiver freezes every cell and req_ready drops.
//   Synchronous reset clears the valid bits of the chain; payload is unreset.
// ----------------------------------------------------------------------------
module photon_direction_power_packer_top (
   input  logic clock,
   input  logic reset,
   pdpp_stream_if.sink   req_if,
   pdpp_stream_if.source rsp_if
);
   import pdpp_pkg::*;

   localparam int ROOT_N = ROOT_W;
   localparam int DEPTH  = ROOT_N + STEPS;

   typedef struct packed {
      logic signed [DIR_W-1:0] direction_x;
      logic signed [DIR_W-1:0] direction_y;
      logic signed [DIR_W-1:0] direction_z;
      logic [POW_W-1:0]        power_red;
      logic [POW_W-1:0]        power_green;
      logic [POW_W-1:0]        power_blue;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] polar_code;
      logic [CODE_W-1:0] azimuth_code;
      logic [CODE_W-1:0] red_mantissa;
      logic [CODE_W-1:0] green_mantissa;
      logic [CODE_W-1:0] blue_mantissa;
      logic [CODE_W-1:0] shared_exponent;
   } rsp_type;

   logic                   advance;
   logic [DEPTH:0]         valid_ff, valid_in;
   rsp_type                out_ff;
   logic                   out_valid_ff;

   req_type in_data;
   assign in_data = req_if.data;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // valid chain: stage 0 is the input register
   always_comb begin
      valid_in = {valid_ff[DEPTH-1:0], req_if.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[DEPTH];
      end
   end

   // stage 0: register input, compute radicand, RGBE and azimuth start vector
   logic signed [DIR_W-1:0] z_ff;
   logic [RAD_W-1:0]        rad_ff;
   rot_type                 azi_ff;
   rgbe_type                rgbe_ff;
   logic signed [2*DIR_W-1:0] zz;
   logic [POW_W-1:0]        top;
   rgbe_type                rgbe_in;
   rot_type                 azi_in;
   vec_type                 ax, ay;

   always_comb begin
      zz  = in_data.direction_z * in_data.direction_z;
      top = in_data.power_red;
      if (in_data.power_green > top) top = in_data.power_green;
      if (in_data.power_blue > top) top = in_data.power_blue;
      if (top < BLACK_LIMIT) begin
         rgbe_in = '0;
      end else begin
         rgbe_in.red   = mant_byte(in_data.power_red, top[30:23]);
         rgbe_in.green = mant_byte(in_data.power_green, top[30:23]);
         rgbe_in.blue  = mant_byte(in_data.power_blue, top[30:23]);
         rgbe_in.expo  = top[30:23] + 8'd2;
      end
      ax = vec_type'(in_data.direction_x) <<< 16;
      ay = vec_type'(in_data.direction_y) <<< 16;
      azi_in.acc = '0;
      azi_in.x   = ax;
      azi_in.y   = ay;
      if (ax < 0) begin
         azi_in.acc = (ay >= 0) ? (acc_type'(1) <<< 31) : -(acc_type'(1) <<< 31);
         azi_in.x   = -ax;
         azi_in.y   = -ay;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff    <= in_data.direction_z;
         rad_ff  <= RAD_W'(32'sh40000000 - zz);
         azi_ff  <= azi_in;
         rgbe_ff <= rgbe_in;
      end
   end

   // square root chain, z delayed alongside
   logic [RAD_W-1:0]        rem_q  [ROOT_N+1];
   logic [RAD_W-1:0]        root_q [ROOT_N+1];
   logic signed [DIR_W-1:0] zd_ff  [ROOT_N];

   assign rem_q[0]  = rad_ff;
   assign root_q[0] = '0;

   for (genvar k = 0; k < ROOT_N; k++) begin : g_root
      pdpp_root_cell #(.BIT_POS(ROOT_N - 1 - k)) u_cell (
         .clock      (clock),
         .enable     (advance),
         .rem_in_d   (rem_q[k]),
         .root_in_d  (root_q[k]),
         .rem_out_q  (rem_q[k+1]),
         .root_out_q (root_q[k+1])
      );
      always_ff @(posedge clock) begin
         if (advance) zd_ff[k] <= (k == 0) ? z_ff : zd_ff[(k == 0) ? 0 : k-1];
      end
   end

   // polar chain
   rot_type pol_q [STEPS+1];
   rot_type pol_start;
   vec_type pz;

   always_comb begin
      pz = vec_type'(zd_ff[ROOT_N-1]) <<< 16;
      pol_start.acc = '0;
      pol_start.x   = pz;
      pol_start.y   = vec_type'({4'b0, root_q[ROOT_N][15:0], 16'b0});
      if (pz < 0) begin
         pol_start.acc = acc_type'(1) <<< 31;
         pol_start.x   = -pz;
         pol_start.y   = -pol_start.y;
      end
   end

   assign pol_q[0] = pol_start;

   // azimuth runs through delay then its own chain, aligned to polar
   rot_type  azd_ff [ROOT_N];
   rgbe_type rgd_ff [DEPTH];
   rot_type  az_q [STEPS+1];

   for (genvar k = 0; k < ROOT_N; k++) begin : g_adly
      always_ff @(posedge clock) begin
         if (advance) azd_ff[k] <= (k == 0) ? azi_ff : azd_ff[(k == 0) ? 0 : k-1];
      end
   end
   for (genvar k = 0; k < DEPTH; k++) begin : g_rdly
      always_ff @(posedge clock) begin
         if (advance) rgd_ff[k] <= (k == 0) ? rgbe_ff : rgd_ff[(k == 0) ? 0 : k-1];
      end
   end

   assign az_q[0] = azd_ff[ROOT_N-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_cordic
      pdpp_cordic_cell #(.STEP(k)) u_pol (
         .clock (clock), .enable (advance),
         .rot_in_d (pol_q[k]), .rot_out_q (pol_q[k+1])
      );
      pdpp_cordic_cell #(.STEP(k)) u_azi (
         .clock (clock), .enable (advance),
         .rot_in_d (az_q[k]), .rot_out_q (az_q[k+1])
      );
   end

   // output register
   acc_type pacc, aacc, amag;
   logic [ACC_W-1:0] pt, at;
   rsp_type out_in;

   always_comb begin
      pacc = pol_q[STEPS].acc;
      aacc = az_q[STEPS].acc;
      pt   = ACC_W'(pacc >>> 23);
      if (pacc < 0)                  out_in.polar_code = '0;
      else if (pt > ACC_W'(255))     out_in.polar_code = 8'hFF;
      else                           out_in.polar_code = pt[7:0];
      amag = (aacc < 0) ? -aacc : aacc;
      at   = ACC_W'(amag >>> 24);
      if (aacc < 0)                  out_in.azimuth_code = 8'(9'd256 - 9'(at));
      else if (at > ACC_W'(255))     out_in.azimuth_code = 8'hFF;
      else                           out_in.azimuth_code = at[7:0];
      out_in.red_mantissa    = rgd_ff[DEPTH-1].red;
      out_in.green_mantissa  = rgd_ff[DEPTH-1].green;
      out_in.blue_mantissa   = rgd_ff[DEPTH-1].blue;
      out_in.shared_exponent = rgd_ff[DEPTH-1].expo;
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff)) else $error("chain moved while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_if.ready) else $error("ready low with empty output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance && valid_ff[DEPTH] |=> out_valid_ff) else $error("result lost");
endmodule

FILE: hdl/pdpp_root_cell.sv
// ----------------------------------------------------------------------------
// pdpp_root_cell
// One digit step of the restoring square root, registered.
// ----------------------------------------------------------------------------
module pdpp_root_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [pdpp_pkg::RAD_W-1:0] rem_in_d,
   input  logic [pdpp_pkg::RAD_W-1:0] root_in_d,
   output logic [pdpp_pkg::RAD_W-1:0] rem_out_q,
   output logic [pdpp_pkg::RAD_W-1:0] root_out_q
);
   import pdpp_pkg::*;

   localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * BIT_POS);

   logic [RAD_W-1:0] rem_ff, rem_in, root_ff, root_in, trial;

   always_comb begin
      trial = root_in_d + BIT;
      if (rem_in_d >= trial) begin
         rem_in  = rem_in_d - trial;
         root_in = (root_in_d >> 1) + BIT;
      end else begin
         rem_in  = rem_in_d;
         root_in = root_in_d >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_out_q  = rem_ff;
   assign root_out_q = root_ff;
endmodule

FILE: hdl/pdpp_cordic_cell.sv
// ----------------------------------------------------------------------------
// pdpp_cordic_cell
// One vectoring rotation of the arctangent chain, registered.
// ----------------------------------------------------------------------------
module pdpp_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              enable,
   input  pdpp_pkg::rot_type rot_in_d,
   output pdpp_pkg::rot_type rot_out_q
);
   import pdpp_pkg::*;

   rot_type rot_ff, rot_in;

   always_comb begin
      rot_in = rot_in_d;
      if (rot_in_d.y > 0) begin
         rot_in.x   = rot_in_d.x + (rot_in_d.y >>> STEP);
         rot_in.y   = rot_in_d.y - (rot_in_d.x >>> STEP);
         rot_in.acc = rot_in_d.acc + atan_unit(STEP);
      end else if (rot_in_d.y < 0) begin
         rot_in.x   = rot_in_d.x - (rot_in_d.y >>> STEP);
         rot_in.y   = rot_in_d.y + (rot_in_d.x >>> STEP);
         rot_in.acc = rot_in_d.acc - atan_unit(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) rot_ff <= rot_in;
   end

   assign rot_out_q = rot_ff;
endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the photon direction and power packer.
// Each photon is sent on the request channel and its packed angle bytes and
// RGBE bytes are predicted in parallel. The results are compared in order
// against the predictions while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pdpp_pkg::*;

   typedef struct packed {
      logic signed [DIR_W-1:0] direction_x;
      logic signed [DIR_W-1:0] direction_y;
      logic signed [DIR_W-1:0] direction_z;
      logic [POW_W-1:0]        power_red;
      logic [POW_W-1:0]        power_green;
      logic [POW_W-1:0]        power_blue;
   } photon_type;

   typedef struct packed {
      logic [CODE_W-1:0] polar_code;
      logic [CODE_W-1:0] azimuth_code;
      logic [CODE_W-1:0] red_mantissa;
      logic [CODE_W-1:0] green_mantissa;
      logic [CODE_W-1:0] blue_mantissa;
      logic [CODE_W-1:0] shared_exponent;
   } packed_photon_type;

   localparam int LATENCY    = 41;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_N   = 1650;
   localparam logic [POW_W-1:0] INF_BITS = 31'h7F800000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pdpp_stream_if #(.payload_type(photon_type))        req_if ();
   pdpp_stream_if #(.payload_type(packed_photon_type)) rsp_if ();

   photon_direction_power_packer_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   packed_photon_type pending_q[$];
   int  mismatches = 0;
   int  photons_sent = 0;
   int  photons_checked = 0;
   int  idle_cycles = 0;
   int  black_seen = 0;
   bit  stall_on = 1'b1;

   function automatic longint turn_unit(input int i);
      longint units[STEPS] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
         64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
         64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
         64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
         64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
      return units[i];
   endfunction

   function automatic longint vector_angle(input longint x, input longint y);
      longint acc, dx, dy;
      acc = 0;
      x = x * 65536;
      y = y * 65536;
      if (x < 0) begin
         acc = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; acc = acc + turn_unit(i);
         end else if (y < 0) begin
            x = x - dx; y = y + dy; acc = acc - turn_unit(i);
         end
      end
      return acc;
   endfunction

   function automatic longint int_root(input longint n);
      longint root, b;
      root = 0;
      b = 64'd1 << 30;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic logic [7:0] scaled_mantissa(input logic [POW_W-1:0] bits,
                                                  input longint top_exp);
      longint e, m, sh;
      e = bits[30:23];
      m = bits[22:0];
      if (e == 0) e = 1;
      else m = m | 64'h800000;
      if (e > top_exp) return 8'd0;
      sh = top_exp - e + 16;
      if (sh >= 64) return 8'd0;
      return 8'((m >> sh) & 64'hFF);
   endfunction

   function automatic packed_photon_type pack_photon(input photon_type p);
      packed_photon_type r;
      longint acc, t, z, top, te;
      z = longint'(p.direction_z);
      acc = vector_angle(z, int_root((64'sd1 << 30) - z * z));
      t = (acc < 0) ? 0 : (acc >>> 23);
      if (t > 255) t = 255;
      r.polar_code = 8'(t);
      acc = vector_angle(longint'(p.direction_x), longint'(p.direction_y));
      t = (acc >= 0) ? (acc >>> 24) : -((-acc) >>> 24);
      if (t > 255) t = 255;
      if (t < 0) t = t + 256;
      r.azimuth_code = 8'(t);
      top = p.power_red;
      if (p.power_green > top) top = p.power_green;
      if (p.power_blue > top) top = p.power_blue;
      if (top < BLACK_LIMIT) begin
         r.red_mantissa = 8'd0;
         r.green_mantissa = 8'd0;
         r.blue_mantissa = 8'd0;
         r.shared_exponent = 8'd0;
      end else begin
         te = (top >> 23) & 64'hFF;
         r.red_mantissa = scaled_mantissa(p.power_red, te);
         r.green_mantissa = scaled_mantissa(p.power_green, te);
         r.blue_mantissa = scaled_mantissa(p.power_blue, te);
         r.shared_exponent = 8'((te + 2) & 64'hFF);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      packed_photon_type want, got;
      if (!reset && req_if.valid && req_if.ready) begin
         want = pack_photon(req_if.data);
         pending_q.push_back(want);
         if (want.shared_exponent == 8'd0 && want.red_mantissa == 8'd0) black_seen++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer: %p", got);
         end else begin
            want = pending_q.pop_front();
            photons_checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch %0d: expected %p, got %p", photons_checked, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_q.size());
         $display("testbench failed");
         $finish;
      end
   end

   logic [31:0] stall_bits = '1;
   int          stall_phase = 0;
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_bits <= ($urandom_range(0, 3) == 0 || !stall_on) ? '1 :
                       ($urandom | $urandom);
         stall_phase <= 31;
      end else begin
         stall_bits <= {stall_bits[30:0], stall_bits[31]};
         stall_phase <= stall_phase - 1;
      end
      rsp_if.ready <= stall_on ? stall_bits[31] : 1'b1;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
   end

   task automatic send_photon(input photon_type p);
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      photons_sent++;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic hold_idle(input int n);
      for (int i = 0; i < n; i++) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   task automatic drain_results();
      hold_idle(1);
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic photon_type make_photon(input logic [15:0] x, input logic [15:0] y,
                                              input logic [15:0] z, input logic [30:0] r,
                                              input logic [30:0] g, input logic [30:0] b);
      photon_type p;
      p.direction_x = x; p.direction_y = y; p.direction_z = z;
      p.power_red = r; p.power_green = g; p.power_blue = b;
      return p;
   endfunction

   function automatic logic [30:0] random_channel(input int base_exp);
      int e;
      e = base_exp - $urandom_range(0, 12);
      if ($urandom_range(0, 7) == 0) e = 0;
      if (e < 0) e = 0;
      return {8'(e), 23'($urandom)};
   endfunction

   function automatic photon_type random_photon();
      photon_type p;
      real th, ph;
      int  base;
      if ($urandom_range(0, 4) == 0) begin
         p.direction_x = 16'($urandom);
         p.direction_y = 16'($urandom);
         p.direction_z = 16'($urandom);
      end else begin
         th = $urandom_range(0, 65535) / 65535.0 * 3.14159265358979;
         ph = $urandom_range(0, 65535) / 65535.0 * 6.28318530717959;
         p.direction_x = 16'($rtoi(32767.0 * $sin(th) * $cos(ph)));
         p.direction_y = 16'($rtoi(32767.0 * $sin(th) * $sin(ph)));
         p.direction_z = 16'($rtoi(32767.0 * $cos(th)));
      end
      if ($urandom_range(0, 5) == 0) begin
         p.power_red = 31'($urandom);
         p.power_green = 31'($urandom);
         p.power_blue = 31'($urandom);
      end else begin
         base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                $urandom_range(10, 30) + (($urandom_range(0, 1) == 1) ? 100 : 0);
         p.power_red = random_channel(base);
         p.power_green = random_channel(base);
         p.power_blue = random_channel(base);
      end
      return p;
   endfunction

   task automatic test_direction_corners();
      logic [30:0] one;
      one = 31'h3F800000;
      send_photon(make_photon(16'h7FFF, 16'h0000, 16'h0000, one, one, one));
      send_photon(make_photon(16'h8000, 16'h0000, 16'h0000, one, one, one));
      send_photon(make_photon(16'h0000, 16'h7FFF, 16'h0000, one, one, one));
      send_photon(make_photon(16'h0000, 16'h8000, 16'h0000, one, one, one));
      send_photon(make_photon(16'h0000, 16'h0000, 16'h7FFF, one, one, one));
      send_photon(make_photon(16'h0000, 16'h0000, 16'h8000, one, one, one));
      send_photon(make_photon(16'h8000, 16'h8000, 16'h8000, one, one, one));
      send_photon(make_photon(16'h7FFF, 16'h7FFF, 16'h7FFF, one, one, one));
      send_photon(make_photon(16'h8000, 16'h0001, 16'hFFFF, one, one, one));
      send_photon(make_photon(16'h8000, 16'hFFFF, 16'h0001, one, one, one));
      send_photon(make_photon(16'hA57F, 16'h5A80, 16'h1234, one, one, one));
   endtask

   task automatic test_power_corners();
      send_photon(make_photon(16'h4000, 16'h4000, 16'h4000, 31'h0, 31'h0, 31'h0));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, BLACK_LIMIT - 1, 31'h1, 31'h0));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, BLACK_LIMIT, 31'h1, 31'h7FFFFF));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, INF_BITS, 31'h3F800000, 31'h0));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, 31'h7FFFFFFF, 31'h7F7FFFFF,
                              31'h7F000000));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, 31'h7F7FFFFF, 31'h7F7FFFFF,
                              31'h7F7FFFFF));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, 31'h0A800000, 31'h007FFFFF,
                              31'h00400000));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, 31'h3F7FFFFF, 31'h3E000000,
                              31'h2AAAAAAA));
      send_photon(make_photon(16'h0, 16'h0, 16'h0, 31'h55555555, 31'h2AAAAAAA,
                              31'h55555555));
   endtask

   task automatic test_random_photons();
      int left, burst;
      bit drained;
      left = RANDOM_N;
      drained = 1'b0;
      while (left > 0) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_photon(random_photon());
            left--;
         end
         if (!drained && left <= RANDOM_N / 2) begin
            drain_results();
            drained = 1'b1;
         end
         if (left <= RANDOM_N / 8) stall_on = 1'b1;
         else if (left <= RANDOM_N / 4) stall_on = 1'b0;
         hold_idle($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_direction_corners();
      test_power_corners();
      test_random_photons();
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d photons, checked %0d packed results (%0d black)",
               photons_sent, photons_checked, black_seen);
      $display("mismatches: %0d, results still outstanding: %0d",
               mismatches, pending_q.size());
      if (mismatches == 0 && pending_q.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
